// ===== rtl/core/did_pkg.sv =====
// ----------------------------------------------------------------------------
// did_pkg
// Types, codes and constants shared by the deferred interrupt dispatcher.
// ----------------------------------------------------------------------------
package did_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam logic [7:0] EVENT_BASE_RESET = 8'd128;
  localparam logic [7:0] LOCK_MAX = 8'd255;

  localparam logic [2:0] ACT_REG_VEC = 3'd0;
  localparam logic [2:0] ACT_REG_EVT = 3'd1;
  localparam logic [2:0] ACT_UNREG   = 3'd2;
  localparam logic [2:0] ACT_INTR    = 3'd3;
  localparam logic [2:0] ACT_LOCK    = 3'd4;
  localparam logic [2:0] ACT_UNLOCK  = 3'd5;
  localparam logic [2:0] ACT_RAISE   = 3'd6;

  localparam logic [2:0] KIND_DONE     = 3'd0;
  localparam logic [2:0] KIND_TOP      = 3'd1;
  localparam logic [2:0] KIND_BOTTOM   = 3'd2;
  localparam logic [2:0] KIND_FULL     = 3'd3;
  localparam logic [2:0] KIND_NOTFOUND = 3'd4;
  localparam logic [2:0] KIND_LIMIT    = 3'd5;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] vector;
    logic       has_top;
    logic       has_bottom;
  } req_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] vector_out;
    logic       last;
  } rsp_item_t;

  typedef enum logic [1:0] {
    VSEL_REQ,
    VSEL_ZERO,
    VSEL_EVENT,
    VSEL_ENTRY
  } vsel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FOUND,
    ST_TOP,
    ST_BOT,
    ST_DRAIN,
    ST_CLOSE
  } state_t;

  typedef struct packed {
    logic       load_req;
    logic       start_rank;
    logic       step_rank;
    logic       capture_sel;
    logic       insert;
    logic       ins_evt;
    logic       evt_inc;
    logic       remove;
    logic       set_pend;
    logic       clr_pend;
    logic       drain_clr;
    logic       lock_inc;
    logic       lock_dec;
    logic       emit;
    logic [2:0] emit_kind;
    logic       emit_last;
    vsel_t      emit_vsel;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       full;
    logic       lock_zero;
    logic       lock_one;
    logic       lock_max;
    logic       hit_any;
    logic       match;
    logic       hit_pending;
    logic       hit_bottom;
    logic       sel_top;
    logic       sel_bottom;
    logic       out_free;
  } stat_t;

endpackage

// ===== rtl/core/did_datapath.sv =====
// ----------------------------------------------------------------------------
// did_datapath
// Vector table, lock depth, event counter, rank walker and result register.
// ----------------------------------------------------------------------------
module did_datapath #(
  parameter int TABLE_ENTRIES = did_pkg::TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  did_pkg::req_item_t req,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_data,
  input  did_pkg::cmd_t     cmd,
  output did_pkg::stat_t    stat,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output did_pkg::rsp_item_t rsp
);
  import did_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int RW = $clog2(TABLE_ENTRIES + 1);

  logic [TABLE_ENTRIES-1:0] valid;
  logic [TABLE_ENTRIES-1:0] pending;
  logic [TABLE_ENTRIES-1:0] top;
  logic [TABLE_ENTRIES-1:0] bottom;
  logic [7:0]               vec [TABLE_ENTRIES];
  logic [AW-1:0]            age [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] sel;
  logic [RW-1:0]            rank;
  logic [7:0]               lock_depth;
  logic [7:0]               next_event;
  req_item_t                cur;

  logic [TABLE_ENTRIES-1:0] hit;
  logic [TABLE_ENTRIES-1:0] free;
  logic                     rank_end;
  logic [7:0]               hit_vec;
  logic                     hit_pend;
  logic                     hit_bot;
  logic [AW-1:0]            sel_age;
  logic                     sel_top;
  logic                     sel_bot;
  logic [7:0]               ins_vec;
  logic                     ins_top;
  logic [7:0]               emit_vec;

  assign rank_end = (rank == RW'(TABLE_ENTRIES));
  assign free     = ~valid & (valid + TABLE_ENTRIES'(1));

  always_comb begin
    hit_vec  = '0;
    hit_pend = 1'b0;
    hit_bot  = 1'b0;
    sel_age  = '0;
    sel_top  = 1'b0;
    sel_bot  = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit[i]   = valid[i] && (age[i] == rank[AW-1:0]) && !rank_end;
      hit_vec  = hit_vec | ({8{hit[i]}} & vec[i]);
      hit_pend = hit_pend | (hit[i] & pending[i]);
      hit_bot  = hit_bot | (hit[i] & bottom[i]);
      sel_age  = sel_age | ({AW{sel[i]}} & age[i]);
      sel_top  = sel_top | (sel[i] & top[i]);
      sel_bot  = sel_bot | (sel[i] & bottom[i]);
    end
  end

  assign ins_vec = cmd.ins_evt ? next_event : cur.vector;
  assign ins_top = cmd.ins_evt ? 1'b0 : cur.has_top;

  always_comb begin
    stat.action      = cur.action;
    stat.full        = &valid;
    stat.lock_zero   = (lock_depth == 8'd0);
    stat.lock_one    = (lock_depth == 8'd1);
    stat.lock_max    = (lock_depth == LOCK_MAX);
    stat.hit_any     = |hit;
    stat.match       = (|hit) && (hit_vec == cur.vector);
    stat.hit_pending = hit_pend;
    stat.hit_bottom  = hit_bot;
    stat.sel_top     = sel_top;
    stat.sel_bottom  = sel_bot;
    stat.out_free    = !rsp_valid || !rsp_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      pending <= '0;
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (cmd.insert && free[i]) begin
          valid[i]   <= 1'b1;
          pending[i] <= 1'b0;
        end else if (cmd.remove && sel[i]) begin
          valid[i]   <= 1'b0;
          pending[i] <= 1'b0;
        end else if (cmd.set_pend && sel[i]) begin
          pending[i] <= 1'b1;
        end else if ((cmd.clr_pend && sel[i]) || (cmd.drain_clr && hit[i])) begin
          pending[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (cmd.insert && free[i]) begin
        vec[i]    <= ins_vec;
        top[i]    <= ins_top;
        bottom[i] <= cur.has_bottom;
        age[i]    <= '0;
      end else if (cmd.insert && valid[i]) begin
        age[i] <= age[i] + AW'(1);
      end else if (cmd.remove && valid[i] && !sel[i] && (age[i] > sel_age)) begin
        age[i] <= age[i] - AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cur <= req;
    end
    if (cmd.capture_sel) begin
      sel <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank       <= '0;
      lock_depth <= 8'd0;
      next_event <= EVENT_BASE_RESET;
    end else begin
      if (cmd.start_rank) begin
        rank <= '0;
      end else if (cmd.step_rank) begin
        rank <= rank + RW'(1);
      end
      if (cmd.lock_inc) begin
        lock_depth <= lock_depth + 8'd1;
      end else if (cmd.lock_dec) begin
        lock_depth <= lock_depth - 8'd1;
      end
      if (cfg_valid) begin
        next_event <= cfg_data;
      end else if (cmd.evt_inc) begin
        next_event <= next_event + 8'd1;
      end
    end
  end

  always_comb begin
    unique case (cmd.emit_vsel)
      VSEL_REQ:   emit_vec = cur.vector;
      VSEL_ZERO:  emit_vec = 8'd0;
      VSEL_EVENT: emit_vec = next_event;
      VSEL_ENTRY: emit_vec = hit_vec;
      default:    emit_vec = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.kind       <= cmd.emit_kind;
      rsp.vector_out <= emit_vec;
      rsp.last       <= cmd.emit_last;
    end
  end

endmodule

// ===== rtl/core/did_ctrl.sv =====
// ----------------------------------------------------------------------------
// did_ctrl
// Sequencer that steps each item through execution and, where needed, lookup,
// dispatch and drain.
module did_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  did_pkg::stat_t stat,
  output did_pkg::cmd_t  cmd
);
  import did_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.emit_vsel = VSEL_REQ;
    state_next = state;
    req_stall  = (state != ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (stat.action)
          ACT_REG_VEC: begin
            if (stat.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              cmd.emit_kind = stat.full ? KIND_FULL : KIND_DONE;
              cmd.insert    = !stat.full;
              state_next    = ST_IDLE;
            end
          end
          ACT_REG_EVT: begin
            if (stat.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              cmd.evt_inc   = 1'b1;
              if (stat.full) begin
                cmd.emit_kind = KIND_FULL;
                cmd.emit_vsel = VSEL_ZERO;
              end else begin
                cmd.emit_kind = KIND_DONE;
                cmd.emit_vsel = VSEL_EVENT;
                cmd.insert    = 1'b1;
                cmd.ins_evt   = 1'b1;
              end
              state_next = ST_IDLE;
            end
          end
          ACT_UNREG, ACT_INTR: begin
            cmd.start_rank = 1'b1;
            state_next     = ST_SCAN;
          end
          ACT_RAISE: begin
            if (!stat.lock_max) begin
              cmd.start_rank = 1'b1;
              state_next     = ST_SCAN;
            end else if (stat.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              cmd.emit_kind = KIND_LIMIT;
              state_next    = ST_IDLE;
            end
          end
          ACT_LOCK: begin
            if (stat.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              cmd.emit_vsel = VSEL_ZERO;
              cmd.emit_kind = stat.lock_max ? KIND_LIMIT : KIND_DONE;
              cmd.lock_inc  = !stat.lock_max;
              state_next    = ST_IDLE;
            end
          end
          ACT_UNLOCK: begin
            if (stat.lock_one) begin
              cmd.start_rank = 1'b1;
              state_next     = ST_DRAIN;
            end else if (stat.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              cmd.emit_vsel = VSEL_ZERO;
              cmd.emit_kind = stat.lock_zero ? KIND_LIMIT : KIND_DONE;
              cmd.lock_dec  = !stat.lock_zero;
              state_next    = ST_IDLE;
            end
          end
          default: begin
            if (stat.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              cmd.emit_vsel = VSEL_ZERO;
              cmd.emit_kind = KIND_DONE;
              state_next    = ST_IDLE;
            end
          end
        endcase
      end

      ST_SCAN: begin
        if (!stat.hit_any) begin
          if (stat.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.emit_kind = KIND_NOTFOUND;
            state_next    = ST_IDLE;
          end
        end else if (stat.match) begin
          cmd.capture_sel = 1'b1;
          state_next      = ST_FOUND;
        end else begin
          cmd.step_rank = 1'b1;
        end
      end

      ST_FOUND: begin
        if (stat.action != ACT_UNREG) begin
          state_next = ST_TOP;
        end else if (stat.out_free) begin
          cmd.remove    = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_kind = KIND_DONE;
          state_next    = ST_IDLE;
        end
      end

      ST_TOP: begin
        if (!stat.sel_top) begin
          state_next = ST_BOT;
        end else if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_TOP;
          state_next    = ST_BOT;
        end
      end

      ST_BOT: begin
        if (!stat.lock_zero) begin
          cmd.set_pend = 1'b1;
          state_next   = ST_CLOSE;
        end else if (!stat.sel_bottom) begin
          cmd.clr_pend = 1'b1;
          state_next   = ST_CLOSE;
        end else if (stat.out_free) begin
          cmd.clr_pend  = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_BOTTOM;
          state_next    = ST_CLOSE;
        end
      end

      ST_DRAIN: begin
        if (!stat.hit_any) begin
          cmd.lock_dec = 1'b1;
          state_next   = ST_CLOSE;
        end else if (stat.hit_pending && stat.hit_bottom) begin
          if (stat.out_free) begin
            cmd.drain_clr = 1'b1;
            cmd.step_rank = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_BOTTOM;
            cmd.emit_vsel = VSEL_ENTRY;
          end
        end else begin
          cmd.drain_clr = 1'b1;
          cmd.step_rank = 1'b1;
        end
      end

      ST_CLOSE: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_kind = KIND_DONE;
          cmd.emit_vsel = (stat.action == ACT_UNLOCK) ? VSEL_ZERO : VSEL_REQ;
          state_next    = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/deferred_interrupt_dispatcher.sv =====
// ----------------------------------------------------------------------------
// deferred_interrupt_dispatcher
// Dispatch and unregister look up the vector by walking the table newest first
// at one rank per cycle; an outermost unlock walks it the same way to drain
// pending entries, but a stalled result can hold that walk. One item is in
// work at a time; a result register lets the next item be taken while the
// closing result waits. Synchronous reset clears the table valid and pending
// bits, the lock depth and loads the event base.
// ----------------------------------------------------------------------------
module deferred_interrupt_dispatcher #(
  parameter int TABLE_ENTRIES = did_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  did_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output did_pkg::rsp_item_t rsp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  import did_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  did_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  did_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/core/deferred_interrupt_dispatcher_checker.sv =====
// ----------------------------------------------------------------------------
// deferred_interrupt_dispatcher_checker
// Port level checks of the dispatcher, attached to the top level by bind.
// ----------------------------------------------------------------------------
module deferred_interrupt_dispatcher_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input did_pkg::rsp_item_t rsp
);
  import did_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("Stalled result item changed or dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("Next item accepted before the current one was worked.");

  a_last_matches_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.last == ((rsp.kind != KIND_TOP) && (rsp.kind != KIND_BOTTOM))))
    else $error("Call results must not close an item, closing results must.");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("Result valid after reset.");

endmodule

bind deferred_interrupt_dispatcher deferred_interrupt_dispatcher_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
